// ===== hdl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// shared constants and types of the merge sort engine
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int DATA_W           = 32;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SEG,
		ST_MRG_RD,
		ST_MRG_WR,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

endpackage

// ===== hdl/mse_ram.sv =====
// ----------------------------------------------------------------------------
// mse_ram
// one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module mse_ram #(
	parameter int DEPTH = mse_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [mse_pkg::DATA_W-1:0]     wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH)-1:0]       raddr0,
	input  logic [$clog2(DEPTH)-1:0]       raddr1,
	output logic [mse_pkg::DATA_W-1:0]     rdata0,
	output logic [mse_pkg::DATA_W-1:0]     rdata1
);
	import mse_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// ===== hdl/mse_ctrl.sv =====
// ----------------------------------------------------------------------------
// mse_ctrl
// load / merge pass / emit sequencer with output register
// ----------------------------------------------------------------------------
module mse_ctrl #(
	parameter int MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [mse_pkg::DATA_W-1:0]            s_tdata,
	input  logic                                  s_tlast,
	// output stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [mse_pkg::DATA_W-1:0]            m_tdata,
	output logic                                  m_tlast,
	// memory side
	output logic                                  we0,
	output logic                                  we1,
	output logic [$clog2(MAX_ELEMENTS)-1:0]       waddr,
	output logic [mse_pkg::DATA_W-1:0]            wdata,
	output logic                                  re,
	output logic [$clog2(MAX_ELEMENTS)-1:0]       raddr0,
	output logic [$clog2(MAX_ELEMENTS)-1:0]       raddr1,
	input  logic [mse_pkg::DATA_W-1:0]            b0_rdata0,
	input  logic [mse_pkg::DATA_W-1:0]            b0_rdata1,
	input  logic [mse_pkg::DATA_W-1:0]            b1_rdata0,
	input  logic [mse_pkg::DATA_W-1:0]            b1_rdata1
);
	import mse_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int SW = CW + 2;

	state_t state_q, state_d;

	logic [CW-1:0]     cnt_q, n_q, e_q;
	logic [SW-1:0]     w_q, lo_q, mid_q, hi_q, a_q, b_q, k_q;
	logic              src_q;
	logic              out_valid_q, out_last_q;
	logic [DATA_W-1:0] out_data_q;

	logic              in_xfer, out_free, closes, take_a, emit_load, emit_end;
	logic [CW-1:0]     cnt_inc, e_inc;
	logic [SW-1:0]     n_ext, seg_mid, seg_hi, k_inc, w_dbl;
	logic [DATA_W-1:0] d_a, d_b, d_sel;

	assign n_ext    = SW'(n_q);
	assign in_xfer  = s_tvalid && s_tready;
	assign cnt_inc  = cnt_q + 1'b1;
	assign closes   = s_tlast || (cnt_inc == CW'(MAX_ELEMENTS));
	assign out_free = !out_valid_q || m_tready;
	assign e_inc    = e_q + 1'b1;
	assign emit_end = (e_inc == n_q);

	// segment bounds, clipped to the set size
	always_comb begin
		seg_mid = lo_q + w_q;
		seg_hi  = lo_q + (w_q << 1);
		if (seg_mid > n_ext) begin
			seg_mid = n_ext;
		end
		if (seg_hi > n_ext) begin
			seg_hi = n_ext;
		end
	end

	// merge compare on the source bank; left run wins on ties
	assign d_a    = src_q ? b1_rdata0 : b0_rdata0;
	assign d_b    = src_q ? b1_rdata1 : b0_rdata1;
	assign take_a = (a_q < mid_q) && ((b_q >= hi_q) || ($signed(d_a) <= $signed(d_b)));
	assign d_sel  = take_a ? d_a : d_b;
	assign k_inc  = k_q + 1'b1;
	assign w_dbl  = w_q << 1;
	assign emit_load = (state_q == ST_EMIT_WR) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		we0      = 1'b0;
		we1      = 1'b0;
		waddr    = cnt_q[AW-1:0];
		wdata    = s_tdata;
		re       = 1'b0;
		raddr0   = a_q[AW-1:0];
		raddr1   = b_q[AW-1:0];
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				we0      = in_xfer;
				if (in_xfer && closes) begin
					state_d = (cnt_inc == CW'(1)) ? ST_EMIT_RD : ST_SEG;
				end
			end
			ST_SEG: begin
				state_d = ST_MRG_RD;
			end
			ST_MRG_RD: begin
				re      = 1'b1;
				state_d = ST_MRG_WR;
			end
			ST_MRG_WR: begin
				waddr = k_q[AW-1:0];
				wdata = d_sel;
				we0   = src_q;
				we1   = !src_q;
				if (k_inc == hi_q) begin
					if (hi_q == n_ext && w_dbl >= n_ext) begin
						state_d = ST_EMIT_RD;
					end else begin
						state_d = ST_SEG;
					end
				end else begin
					state_d = ST_MRG_RD;
				end
			end
			ST_EMIT_RD: begin
				re      = 1'b1;
				raddr0  = e_q[AW-1:0];
				state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				raddr0 = e_q[AW-1:0];
				if (out_free) begin
					state_d = emit_end ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			n_q   <= '0;
			e_q   <= '0;
			w_q   <= SW'(1);
			lo_q  <= '0;
			mid_q <= '0;
			hi_q  <= '0;
			a_q   <= '0;
			b_q   <= '0;
			k_q   <= '0;
			src_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						cnt_q <= closes ? '0 : cnt_inc;
						if (closes) begin
							n_q   <= cnt_inc;
							e_q   <= '0;
							w_q   <= SW'(1);
							lo_q  <= '0;
							src_q <= 1'b0;
						end
					end
				end
				ST_SEG: begin
					mid_q <= seg_mid;
					hi_q  <= seg_hi;
					a_q   <= lo_q;
					b_q   <= seg_mid;
					k_q   <= lo_q;
				end
				ST_MRG_WR: begin
					k_q <= k_inc;
					if (take_a) begin
						a_q <= a_q + 1'b1;
					end else begin
						b_q <= b_q + 1'b1;
					end
					if (k_inc == hi_q) begin
						if (hi_q == n_ext) begin
							// pass done: swap banks, double the run width
							src_q <= !src_q;
							w_q   <= w_dbl;
							lo_q  <= '0;
							e_q   <= '0;
						end else begin
							lo_q <= hi_q;
						end
					end
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						e_q <= e_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q <= src_q ? b1_rdata0 : b0_rdata0;
			out_last_q <= emit_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== hdl/merge_sort_engine.sv =====
// ----------------------------------------------------------------------------
// merge_sort_engine
// stable ascending merge sort of signed 32-bit values
// ----------------------------------------------------------------------------
// usage:
//   s_axis: one transfer loads one value (tdata); tlast closes the set. a set
//   also closes when MAX_ELEMENTS values have arrived. tready is high only
//   while loading, one value per cycle.
//   m_axis: after a set closes, every value comes out in ascending order, the
//   final one with tlast high. equal keys keep their arrival order.
// sort scheme:
//   bottom-up merge over two ping-pong banks, ceil(log2(n)) passes. each
//   output slot of a pass reads both run heads, then writes the winner;
//   each run pair starts with a setup step. emit reads each value from
//   memory, then loads it into the output register.
// reset: the sequencer returns to loading with an empty set; memory contents
//   are not cleared; entries not yet written may be read, but that data is never used.
// stall: a result sits in the output register until taken; emission pauses
//   while m_axis_tready is low. a new set may start loading while the last
//   result still waits.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
	parameter int MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [mse_pkg::DATA_W-1:0]  s_axis_tdata,   // [31:0] value
	input  logic                        s_axis_tlast,   // last_element
	// output stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [mse_pkg::DATA_W-1:0]  m_axis_tdata,   // [31:0] sorted_value
	output logic                        m_axis_tlast    // is_last
);
	import mse_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);

	// memory control from the sequencer
	logic              we0, we1, re;
	logic [AW-1:0]     waddr, raddr0, raddr1;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] b0_rdata0, b0_rdata1, b1_rdata0, b1_rdata1;

	// bank 0: element store, loaded from the input stream
	mse_ram #(.DEPTH(MAX_ELEMENTS)) u_bank0 (
		.clk    (clk),
		.we     (we0),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (re),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (b0_rdata0),
		.rdata1 (b0_rdata1)
	);

	// bank 1: merge buffer, source and target swap after every pass
	mse_ram #(.DEPTH(MAX_ELEMENTS)) u_bank1 (
		.clk    (clk),
		.we     (we1),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (re),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (b1_rdata0),
		.rdata1 (b1_rdata1)
	);

	// load, merge passes and emit, plus the output register
	mse_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.s_tlast   (s_axis_tlast),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tlast   (m_axis_tlast),
		.we0       (we0),
		.we1       (we1),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr0    (raddr0),
		.raddr1    (raddr1),
		.b0_rdata0 (b0_rdata0),
		.b0_rdata1 (b0_rdata1),
		.b1_rdata0 (b1_rdata0),
		.b1_rdata1 (b1_rdata1)
	);

endmodule
